// File: rtl/core/p2nc_pkg.sv
package p2nc_pkg;

   localparam int unsigned FREQ_WIDTH  = 24;
   localparam int unsigned A4_WIDTH    = 9;
   localparam int unsigned NOTE_WIDTH  = 4;
   localparam int unsigned OCT_WIDTH   = 5;
   localparam int unsigned CENTS_WIDTH = 7;

   // log2 unit: Q1.31 mantissa, 5-bit exponent, Q.24 fraction
   localparam int unsigned MANT_BITS = 32;
   localparam int unsigned EXP_BITS  = 5;
   localparam int unsigned FRAC_BITS = 24;
   localparam int unsigned LOG_BITS  = EXP_BITS + FRAC_BITS;

   localparam logic [A4_WIDTH-1:0] A4_RESET = 9'd440;

   typedef struct packed {
      logic load;
      logic norm;
      logic square;
      logic diff;
      logic mul;
      logic div;
      logic rem;
      logic pick;
      logic fin;
   } p2nc_cmd_type;

   typedef struct packed {
      logic zero;
      logic normed;
   } p2nc_status_type;

endpackage

// File: rtl/core/p2nc_if.sv
interface p2nc_req_if
   import p2nc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [FREQ_WIDTH-1:0] frequency_fixed;

   modport source (output valid, output frequency_fixed, input ready);
   modport sink   (input valid, input frequency_fixed, output ready);
endinterface

interface p2nc_rsp_if
   import p2nc_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic                          valid_res;
   logic [NOTE_WIDTH-1:0]         note_index;
   logic signed [OCT_WIDTH-1:0]   octave_number;
   logic signed [CENTS_WIDTH-1:0] cents_error;

   modport source (output valid, output valid_res, output note_index,
                   output octave_number, output cents_error, input ready);
   modport sink   (input valid, input valid_res, input note_index,
                   input octave_number, input cents_error, output ready);
endinterface

interface p2nc_csr_if
   import p2nc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [A4_WIDTH-1:0] a4_reference_hz;

   modport source (output valid, output a4_reference_hz, input ready);
   modport sink   (input valid, input a4_reference_hz, output ready);
endinterface

// File: rtl/core/p2nc_log_lane.sv
module p2nc_log_lane
   import p2nc_pkg::*;
(
   input  logic                 clock,
   input  logic                 load,
   input  logic                 norm,
   input  logic                 square,
   input  logic [MANT_BITS-1:0] value,
   output logic                 normed,
   output logic [LOG_BITS-1:0]  log_q24
);

   logic [MANT_BITS-1:0]   mant_ff, mant_in;
   logic [EXP_BITS-1:0]    exp_ff, exp_in;
   logic [FRAC_BITS-1:0]   frac_ff, frac_in;
   logic [2*MANT_BITS-1:0] sq;
   logic [MANT_BITS:0]     sq_top;

   assign sq     = mant_ff * mant_ff;
   assign sq_top = sq[2*MANT_BITS-1 -: MANT_BITS+1];

   always_comb begin
      mant_in = mant_ff;
      exp_in  = exp_ff;
      frac_in = frac_ff;
      if (load) begin
         mant_in = value;
         exp_in  = EXP_BITS'(MANT_BITS-1);
         frac_in = '0;
      end else if (norm && !mant_ff[MANT_BITS-1]) begin
         // one bit a cycle until the leading one reaches the top
         mant_in = {mant_ff[MANT_BITS-2:0], 1'b0};
         exp_in  = exp_ff - EXP_BITS'(1);
      end else if (square) begin
         // square of [1,2) lands in [1,4); >= 2 yields a one bit
         frac_in = {frac_ff[FRAC_BITS-2:0], sq_top[MANT_BITS]};
         mant_in = sq_top[MANT_BITS] ? sq_top[MANT_BITS:1] : sq_top[MANT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      mant_ff <= mant_in;
      exp_ff  <= exp_in;
      frac_ff <= frac_in;
   end

   assign normed  = mant_ff[MANT_BITS-1];
   assign log_q24 = {exp_ff, frac_ff};

endmodule

// File: rtl/core/p2nc_datapath.sv
module p2nc_datapath
   import p2nc_pkg::*;
(
   input  logic                          clock,
   input  p2nc_cmd_type                  cmd,
   input  logic [FREQ_WIDTH-1:0]         frequency_fixed,
   input  logic [A4_WIDTH-1:0]           a4_reference_hz,
   output p2nc_status_type               status,
   output logic                          valid_res,
   output logic [NOTE_WIDTH-1:0]         note_index,
   output logic signed [OCT_WIDTH-1:0]   octave_number,
   output logic signed [CENTS_WIDTH-1:0] cents_error
);

   localparam int unsigned DIFF_BITS = LOG_BITS + 2;
   localparam int unsigned C_BITS    = 42;
   localparam int unsigned T_BITS    = 14;
   localparam int unsigned Q_BITS    = 9;
   localparam int unsigned LOW_BITS  = 26;
   localparam int unsigned X_BITS    = 31;
   localparam int unsigned ERR_BITS  = 33;
   localparam int unsigned NOTE_BITS = 10;
   localparam int unsigned NP_BITS   = 11;
   localparam int unsigned OQ_BITS   = 8;

   localparam logic signed [DIFF_BITS-1:0] EIGHT_Q24  = DIFF_BITS'(8) << FRAC_BITS;
   localparam logic signed [C_BITS-1:0]    CENTS_MUL  = 42'sd1200;
   localparam logic signed [C_BITS-1:0]    C4_OFFSET  = C_BITS'(900) << FRAC_BITS;
   // s = floor(c / (25 * 2^26)); bias by 25*256 to keep the quotient positive
   localparam logic signed [C_BITS-1:0]    DIV_BIAS   = 42'sd6400;
   localparam logic [12:0]                 RECIP_25   = 13'd5243;
   localparam logic [Q_BITS:0]             SEMI_BIAS  = 10'd256;
   localparam logic [X_BITS-1:0]           TIE_Q24    = 31'd850972743;
   localparam logic [ERR_BITS-1:0]         SEMI_Q24   = ERR_BITS'(100) << FRAC_BITS;
   localparam logic [31:0]                 HALF_Q24   = 32'd1 << (FRAC_BITS-1);
   localparam logic [NP_BITS-1:0]          NOTE_BIAS  = 11'd384;
   localparam logic [11:0]                 RECIP_12   = 12'd2731;
   localparam logic [OQ_BITS-1:0]          OQ_LOW     = 8'd12;
   localparam logic [OQ_BITS-1:0]          OQ_HIGH    = 8'd43;
   localparam logic [OQ_BITS-1:0]          OQ_TO_OCT  = 8'd28;

   logic                        normed_f, normed_a;
   logic [LOG_BITS-1:0]         log_f, log_a;
   logic                        zero_ff;

   logic signed [DIFF_BITS-1:0] d_ff;
   logic signed [C_BITS-1:0]    c_ff;
   logic [T_BITS-1:0]           t_ff, t_in;
   logic [Q_BITS-1:0]           q_ff, q_in;
   logic [LOW_BITS-1:0]         low_ff;
   logic [26:0]                 q_prod;
   logic [X_BITS-1:0]           x_ff, x_in;
   logic signed [NOTE_BITS-1:0] s_ff, s_in;
   logic [T_BITS-1:0]           r_full;
   logic signed [NOTE_BITS-1:0] note_ff, note_in;
   logic signed [CENTS_WIDTH-1:0] cents_ff, cents_in;
   logic                        above;
   logic [ERR_BITS-1:0]         err;
   logic [31:0]                 mag;
   logic [31:0]                 rnd;
   logic [CENTS_WIDTH-1:0]      rc;
   logic [NP_BITS-1:0]          np;
   logic [22:0]                 oq_prod;
   logic [OQ_BITS-1:0]          oq;
   logic [NP_BITS-1:0]          idx_full;
   logic                        oct_ok;

   logic                          valid_res_ff;
   logic [NOTE_WIDTH-1:0]         note_index_ff;
   logic signed [OCT_WIDTH-1:0]   octave_number_ff;
   logic signed [CENTS_WIDTH-1:0] cents_error_ff;

   p2nc_log_lane u_lane_f (
      .clock   (clock),
      .load    (cmd.load),
      .norm    (cmd.norm),
      .square  (cmd.square),
      .value   (MANT_BITS'(frequency_fixed)),
      .normed  (normed_f),
      .log_q24 (log_f)
   );

   p2nc_log_lane u_lane_a (
      .clock   (clock),
      .load    (cmd.load),
      .norm    (cmd.norm),
      .square  (cmd.square),
      .value   (MANT_BITS'(a4_reference_hz)),
      .normed  (normed_a),
      .log_q24 (log_a)
   );

   assign status.zero   = zero_ff;
   assign status.normed = normed_f && normed_a;

   // quotient and remainder by 25
   assign t_in   = T_BITS'((c_ff >>> LOW_BITS) + DIV_BIAS);
   assign q_prod = t_in * RECIP_25;
   assign q_in   = q_prod[17 +: Q_BITS];

   assign r_full = t_ff - (T_BITS'(q_ff) * T_BITS'(25));
   assign x_in   = {r_full[4:0], low_ff};
   assign s_in   = $signed({1'b0, q_ff} - SEMI_BIAS);

   // nearer neighbor, then round half away from zero
   assign above    = x_ff > TIE_Q24;
   assign err      = above ? (ERR_BITS'(x_ff) - SEMI_Q24) : ERR_BITS'(x_ff);
   assign mag      = err[ERR_BITS-1] ? 32'(-err) : err[31:0];
   assign rnd      = mag + HALF_Q24;
   assign rc       = rnd[FRAC_BITS +: CENTS_WIDTH];
   assign cents_in = err[ERR_BITS-1] ? $signed(-rc) : $signed(rc);
   assign note_in  = s_ff + NOTE_BITS'(above);

   // octave and note index by 12
   assign np       = NP_BITS'(note_ff) + NOTE_BIAS;
   assign oq_prod  = np * RECIP_12;
   assign oq       = oq_prod[15 +: OQ_BITS];
   assign idx_full = np - (NP_BITS'(oq) * NP_BITS'(12));
   assign oct_ok   = (oq >= OQ_LOW) && (oq <= OQ_HIGH);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zero_ff <= (frequency_fixed == '0) || (a4_reference_hz == '0);
      end
      if (cmd.diff) begin
         d_ff <= DIFF_BITS'(log_f) - DIFF_BITS'(log_a) - EIGHT_Q24;
      end
      if (cmd.mul) begin
         c_ff <= C_BITS'(d_ff) * CENTS_MUL + C4_OFFSET;
      end
      if (cmd.div) begin
         t_ff   <= t_in;
         q_ff   <= q_in;
         low_ff <= c_ff[LOW_BITS-1:0];
      end
      if (cmd.rem) begin
         x_ff <= x_in;
         s_ff <= s_in;
      end
      if (cmd.pick) begin
         note_ff  <= note_in;
         cents_ff <= cents_in;
      end
      if (cmd.fin) begin
         if (zero_ff || !oct_ok) begin
            valid_res_ff     <= 1'b0;
            note_index_ff    <= '0;
            octave_number_ff <= '0;
            cents_error_ff   <= '0;
         end else begin
            valid_res_ff     <= 1'b1;
            note_index_ff    <= idx_full[NOTE_WIDTH-1:0];
            octave_number_ff <= $signed(OCT_WIDTH'(oq - OQ_TO_OCT));
            cents_error_ff   <= cents_ff;
         end
      end
   end

   assign valid_res     = valid_res_ff;
   assign note_index    = note_index_ff;
   assign octave_number = octave_number_ff;
   assign cents_error   = cents_error_ff;

endmodule

// File: rtl/core/p2nc_ctrl.sv
module p2nc_ctrl
   import p2nc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  p2nc_status_type status,
   output p2nc_cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_NORM = 9'b000000010,
      ST_SQR  = 9'b000000100,
      ST_DIFF = 9'b000001000,
      ST_MUL  = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_REM  = 9'b001000000,
      ST_PICK = 9'b010000000,
      ST_FIN  = 9'b100000000
   } state_type;

   localparam int unsigned CNT_BITS = $clog2(FRAC_BITS);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] sq_cnt_ff, sq_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      sq_cnt_in    = sq_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm  = 1'b1;
            sq_cnt_in = '0;
            if (status.zero) begin
               state_in = ST_FIN;
            end else if (status.normed) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            cmd.square = 1'b1;
            sq_cnt_in  = sq_cnt_ff + CNT_BITS'(1);
            if (sq_cnt_ff == CNT_BITS'(FRAC_BITS-1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.rem  = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sq_cnt_ff <= sq_cnt_in;
   end

endmodule

// File: rtl/core/pitch_to_note_cents.sv
// channel   direction  payload
// req_bus   in         frequency_fixed (Q16.8 Hz)
// rsp_bus   out        valid_res, note_index, octave_number, cents_error
// csr_bus   in         a4_reference_hz (always ready)
//
// One transfer in flight. From req transfer to result: load, then normalize (one-bit
// shifts set by the smaller leading one, plus the state that sees both normalized),
// then squaring in the two 32x32 log2 lanes, then post arithmetic in the states
// diff, mul, div, rem, pick and fin. A zero operand goes from normalize straight to
// the final state. req_bus becomes ready at the same edge that registers the result.
// A held result does not block the next req transfer; the next result waits in
// the final state until rsp_bus drains. Reset is synchronous; A4 resets to 440.
module pitch_to_note_cents
   import p2nc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   p2nc_req_if.sink   req_bus,
   p2nc_rsp_if.source rsp_bus,
   p2nc_csr_if.sink   csr_bus
);

   logic [A4_WIDTH-1:0] a4_ff;
   p2nc_cmd_type        cmd;
   p2nc_status_type     status;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a4_ff <= A4_RESET;
      end else if (csr_bus.valid) begin
         a4_ff <= csr_bus.a4_reference_hz;
      end
   end

   p2nc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   p2nc_datapath u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .frequency_fixed (req_bus.frequency_fixed),
      .a4_reference_hz (a4_ff),
      .status          (status),
      .valid_res       (rsp_bus.valid_res),
      .note_index      (rsp_bus.note_index),
      .octave_number   (rsp_bus.octave_number),
      .cents_error     (rsp_bus.cents_error)
   );

endmodule

// File: dv/tb_top.sv
typedef struct packed {
   logic               vld;
   logic [3:0]         idx;
   logic signed [4:0]  oct;
   logic signed [6:0]  cents;
} tuner_result_type;

localparam longint UNIT_Q24     = 64'sd16777216;
localparam longint SEMITONE_Q24 = 100 * UNIT_Q24;
// midpoint between two neighboring notes, in cents above the lower one
localparam longint TIE_Q24      = 64'sd850972743;

class tuning_scoreboard;
   logic [8:0]       a4_hz;
   tuner_result_type expected_notes[$];
   int               failures;
   int               checked;

   function new();
      a4_hz    = p2nc_pkg::A4_RESET;
      failures = 0;
      checked  = 0;
   endfunction

   function void set_reference(logic [8:0] hz);
      a4_hz = hz;
   endfunction

   function int depth();
      return expected_notes.size();
   endfunction

   // log2 in Q8.24: leading one for the integer part, repeated squaring for the fraction
   function longint log2_fixed(logic [23:0] v);
      logic [63:0] mant;
      longint      lead;
      longint      frac;
      lead = 0;
      frac = 0;
      for (int i = 0; i < 24; i++)
         if (v[i]) lead = i;
      mant = 64'(v) << (31 - lead);
      for (int i = 0; i < 24; i++) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant[32]) begin
            frac = frac | 1;
            mant = mant >> 1;
         end
      end
      return (lead << 24) | frac;
   endfunction

   function longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) < 0) q = q - 1;
      return q;
   endfunction

   function tuner_result_type predict_note(logic [23:0] f);
      tuner_result_type r;
      longint        log_diff;
      longint        total;
      longint        semi;
      longint        rem;
      longint        err;
      longint        note;
      longint        rounded;
      longint        oct_div;
      longint        octave;
      r = '0;
      if (f == 0 || a4_hz == 0) return r;
      log_diff = log2_fixed(f) - log2_fixed(24'(a4_hz)) - 8 * UNIT_Q24;
      total    = 1200 * log_diff + 900 * UNIT_Q24;
      semi  = floor_div(total, SEMITONE_Q24);
      rem   = total - semi * SEMITONE_Q24;
      if (rem <= TIE_Q24) begin
         note = semi;
         err  = rem;
      end else begin
         note = semi + 1;
         err  = rem - SEMITONE_Q24;
      end
      if (err >= 0)
         rounded = (err + UNIT_Q24 / 2) >>> 24;
      else
         rounded = -((-err + UNIT_Q24 / 2) >>> 24);
      oct_div = floor_div(note, 12);
      octave  = 4 + oct_div;
      if (octave < -16 || octave > 15) return r;
      r.vld   = 1'b1;
      r.idx   = 4'(note - 12 * oct_div);
      r.oct   = 5'(octave);
      r.cents = 7'(rounded);
      return r;
   endfunction

   function void note_input(logic [23:0] f);
      expected_notes.push_back(predict_note(f));
   endfunction

   function void check_result(tuner_result_type got);
      tuner_result_type want;
      if (expected_notes.size() == 0) begin
         $display("%0t: unexpected result valid_res=%0d note=%0d octave=%0d cents=%0d",
                  $time, got.vld, got.idx, got.oct, got.cents);
         failures++;
         return;
      end
      want = expected_notes.pop_front();
      checked++;
      if (got.vld !== want.vld) begin
         $display("%0t: valid_res expected %0d got %0d", $time, want.vld, got.vld);
         failures++;
      end
      if (got.idx !== want.idx) begin
         $display("%0t: note_index expected %0d got %0d", $time, want.idx, got.idx);
         failures++;
      end
      if (got.oct !== want.oct) begin
         $display("%0t: octave_number expected %0d got %0d", $time, want.oct, got.oct);
         failures++;
      end
      if (got.cents !== want.cents) begin
         $display("%0t: cents_error expected %0d got %0d", $time, want.cents, got.cents);
         failures++;
      end
   endfunction
endclass

module tb_top;
   import p2nc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic             clock;
   logic             reset;
   int               cycles = 0;
   bit               long_hold_done = 0;
   tuning_scoreboard sb = new();

   p2nc_req_if req_bus ();
   p2nc_rsp_if rsp_bus ();
   p2nc_csr_if csr_bus ();

   pitch_to_note_cents dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("pitch_to_note_cents regression: fail");
         $finish;
      end
   end

   // transfer monitor: all three channels sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.set_reference(csr_bus.a4_reference_hz);
         if (req_bus.valid && req_bus.ready)
            sb.note_input(req_bus.frequency_fixed);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result('{rsp_bus.valid_res, rsp_bus.note_index,
                              rsp_bus.octave_number, rsp_bus.cents_error});
      end
   end

   // result-side backpressure, with one long hold to fill the block
   initial begin
      int pick;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (!long_hold_done && sb.checked >= 40) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold_done = 1;
         end else if (pick < 45) begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else if (pick < 92) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   function automatic logic [23:0] pick_frequency(int unsigned a4);
      int  pick;
      int  note;
      int  lead;
      real base;
      real scale;
      real val;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         // near a note center, a note midpoint or within 60 cents of a center
         note = int'($urandom_range(0, 215)) - 120;
         base = ((a4 == 0) ? 440.0 : real'(a4)) * (2.0 ** (real'(note - 9) / 12.0)) * 256.0;
         case ($urandom_range(0, 3))
            0: scale = 1.0;
            1: scale = (1.0 + 2.0 ** (1.0 / 12.0)) / 2.0;
            2: scale = (1.0 + 2.0 ** (-1.0 / 12.0)) / 2.0;
            default: scale = 2.0 ** (real'(int'($urandom_range(0, 120)) - 60) / 1200.0);
         endcase
         val = base * scale + real'(int'($urandom_range(0, 6)) - 3);
         if (val < 1.0) return 24'd1;
         if (val > 16777215.0) return 24'hFFFFFF;
         return 24'($rtoi(val));
      end else if (pick < 80) begin
         lead = $urandom_range(0, 23);
         return 24'((32'd1 << lead) | ($urandom & ((32'd1 << lead) - 1)));
      end else if (pick < 96) begin
         return 24'($urandom);
      end else begin
         case ($urandom_range(0, 3))
            0: return 24'd0;
            1: return 24'd1;
            2: return 24'hFFFFFF;
            default: return 24'h800000;
         endcase
      end
   endfunction

   task automatic send_frequency(logic [23:0] f);
      int pick;
      int gap;
      req_bus.valid           <= 1'b1;
      req_bus.frequency_fixed <= f;
      do @(posedge clock); while (!req_bus.ready);
      pick = $urandom_range(0, 99);
      if (pick < 40) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 4);
      else gap = $urandom_range(10, 50);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(int count, int unsigned a4);
      repeat (count) send_frequency(pick_frequency(a4));
   endtask

   // quiet point: input idle and every expected note delivered
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.depth() != 0);
   endtask

   task automatic write_reference(logic [8:0] hz);
      csr_bus.valid           <= 1'b1;
      csr_bus.a4_reference_hz <= hz;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      logic [23:0] directed [$];
      int unsigned a4;
      int          count;
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.frequency_fixed <= '0;
      csr_bus.valid           <= 1'b0;
      csr_bus.a4_reference_hz <= A4_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, exact A's, powers of two, midpoints incl. the B-to-C wrap
      directed = '{24'd0, 24'd1, 24'd2, 24'd3, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                   24'h555555, 24'hAAAAAA, 24'd256, 24'd56320, 24'd112640, 24'd225280,
                   24'd66976, 24'd115940, 24'd115941, 24'd130190, 24'd130200,
                   24'd65093, 24'd16384, 24'd8388607};
      foreach (directed[i]) send_frequency(directed[i]);
      send_random(300, 440);

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin a4 = 400; count = 120; end
            1: begin a4 = 480; count = 120; end
            2: begin a4 = 0;   count = 25;  end
            3: begin a4 = 1;   count = 50;  end
            4: begin a4 = 511; count = 60;  end
            5: begin a4 = 256; count = 30;  end
            default: begin a4 = $urandom_range(400, 480); count = 200; end
         endcase
         drain();
         write_reference(9'(a4));
         send_random(count, a4);
      end

      drain();
      repeat (80) @(posedge clock);
      if (sb.failures == 0)
         $display("pitch_to_note_cents regression: pass");
      else
         $display("pitch_to_note_cents regression: fail");
      $finish;
   end
endmodule
